// File: hdl/hsvg_pkg.sv
`default_nettype none
package hsvg_pkg;

    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int LEVEL_W = 8;
    localparam int REM_W   = 6;
    localparam int K_W     = 15;
    localparam int FRAC_W  = 13;
    localparam int NP_W    = K_W + PCT_W;
    localparam int NQ_W    = K_W + FRAC_W;

    localparam logic [HUE_W-1:0]  HUE_FULL   = 9'd360;
    localparam logic [HUE_W-1:0]  SECTOR_DEG = 9'd60;
    localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
    localparam logic [FRAC_W-1:0] FRAC_FULL  = 13'd6000;

    localparam int DIV_VO = 100;
    localparam int DIV_P  = 10000;
    localparam int DIV_QT = 600000;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

endpackage
`default_nettype wire

// File: hdl/hsv_to_grb_color_unit.sv
`default_nettype none
// hsv to grb color conversion, six register stages
// throughput: one transaction per cycle
// pipeline stages: clamp/sector, scaling, products, constant dividers (estimate, correction), swap
// busy is always low and the receiver cannot stall the pipeline
// synchronous active-low reset clears the stage valid bits only
module hsv_to_grb_color_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [hsvg_pkg::HUE_W-1:0]      i_hue_degrees,
    input  wire logic [hsvg_pkg::PCT_W-1:0]      i_saturation_percent,
    input  wire logic [hsvg_pkg::PCT_W-1:0]      i_value_percent,
    output logic                                 o_done,
    output logic      [hsvg_pkg::LEVEL_W-1:0]    o_red_level,
    output logic      [hsvg_pkg::LEVEL_W-1:0]    o_green_level,
    output logic      [hsvg_pkg::LEVEL_W-1:0]    o_blue_level,
    output logic      [3*hsvg_pkg::LEVEL_W-1:0]  o_packed_color
);
    import hsvg_pkg::*;

    localparam int STAGES = 6;

    logic              n_accept;
    logic [STAGES-1:0] r_vld;

    // stage 1
    logic [HUE_W-1:0] n_hue;
    logic [HUE_W-1:0] n_base;
    t_sector          n_sec1;
    t_sector          r_sec1;
    logic [REM_W-1:0] r_rem1;
    logic [PCT_W-1:0] n_sat;
    logic [PCT_W-1:0] n_val;
    logic [PCT_W-1:0] r_sat1;
    logic [PCT_W-1:0] r_val1;

    // stage 2
    t_sector           r_sec2;
    logic [K_W-1:0]    r_k2;
    logic [PCT_W-1:0]  r_ap2;
    logic [FRAC_W-1:0] r_aq2;
    logic [FRAC_W-1:0] r_at2;
    logic [FRAC_W-1:0] n_rs;
    logic [FRAC_W-1:0] n_crs;

    // stage 3
    t_sector          r_sec3;
    logic [K_W-1:0]   r_k3;
    logic [NP_W-1:0]  r_np3;
    logic [NQ_W-1:0]  r_nq3;
    logic [NQ_W-1:0]  r_nt3;

    // stages 4 and 5 live in the dividers
    t_sector            r_sec4;
    t_sector            r_sec5;
    logic [LEVEL_W-1:0] w_vo;
    logic [LEVEL_W-1:0] w_p;
    logic [LEVEL_W-1:0] w_q;
    logic [LEVEL_W-1:0] w_t;

    // stage 6
    logic [LEVEL_W-1:0] n_red;
    logic [LEVEL_W-1:0] n_green;
    logic [LEVEL_W-1:0] n_blue;
    logic [LEVEL_W-1:0] r_red;
    logic [LEVEL_W-1:0] r_green;
    logic [LEVEL_W-1:0] r_blue;

    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], n_accept};
        end
    end

    always_comb begin
        n_sat = (i_saturation_percent > PCT_FULL) ? PCT_FULL : i_saturation_percent;
        n_val = (i_value_percent > PCT_FULL) ? PCT_FULL : i_value_percent;
        // full circle and beyond fold to zero degrees
        n_hue = (i_hue_degrees >= HUE_FULL) ? '0 : i_hue_degrees;
        if (n_hue >= HUE_W'(5 * SECTOR_DEG)) begin
            n_sec1 = SEC_MR;
            n_base = HUE_W'(5 * SECTOR_DEG);
        end else if (n_hue >= HUE_W'(4 * SECTOR_DEG)) begin
            n_sec1 = SEC_BM;
            n_base = HUE_W'(4 * SECTOR_DEG);
        end else if (n_hue >= HUE_W'(3 * SECTOR_DEG)) begin
            n_sec1 = SEC_CB;
            n_base = HUE_W'(3 * SECTOR_DEG);
        end else if (n_hue >= HUE_W'(2 * SECTOR_DEG)) begin
            n_sec1 = SEC_GC;
            n_base = HUE_W'(2 * SECTOR_DEG);
        end else if (n_hue >= SECTOR_DEG) begin
            n_sec1 = SEC_YG;
            n_base = SECTOR_DEG;
        end else begin
            n_sec1 = SEC_RY;
            n_base = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec1 <= n_sec1;
        r_rem1 <= REM_W'(n_hue - n_base);
        r_sat1 <= n_sat;
        r_val1 <= n_val;
    end

    always_comb begin
        n_rs  = FRAC_W'(r_rem1) * FRAC_W'(r_sat1);
        n_crs = FRAC_W'(REM_W'(SECTOR_DEG) - r_rem1) * FRAC_W'(r_sat1);
    end

    always_ff @(posedge i_clk) begin
        r_sec2 <= r_sec1;
        r_k2   <= (K_W'(r_val1) << LEVEL_W) - K_W'(r_val1);
        r_ap2  <= PCT_FULL - r_sat1;
        r_aq2  <= FRAC_FULL - n_rs;
        r_at2  <= FRAC_FULL - n_crs;
    end

    always_ff @(posedge i_clk) begin
        r_sec3 <= r_sec2;
        r_k3   <= r_k2;
        r_np3  <= NP_W'(r_k2) * NP_W'(r_ap2);
        r_nq3  <= NQ_W'(r_k2) * NQ_W'(r_aq2);
        r_nt3  <= NQ_W'(r_k2) * NQ_W'(r_at2);
    end

    hsvg_cdiv #(.XW(K_W), .DIV(DIV_VO), .SHIFT(16)) u_div_vo (
        .i_clk (i_clk),
        .i_x   (r_k3),
        .o_q   (w_vo)
    );

    hsvg_cdiv #(.XW(NP_W), .DIV(DIV_P), .SHIFT(26)) u_div_p (
        .i_clk (i_clk),
        .i_x   (r_np3),
        .o_q   (w_p)
    );

    hsvg_cdiv #(.XW(NQ_W), .DIV(DIV_QT), .SHIFT(32)) u_div_q (
        .i_clk (i_clk),
        .i_x   (r_nq3),
        .o_q   (w_q)
    );

    hsvg_cdiv #(.XW(NQ_W), .DIV(DIV_QT), .SHIFT(32)) u_div_t (
        .i_clk (i_clk),
        .i_x   (r_nt3),
        .o_q   (w_t)
    );

    always_ff @(posedge i_clk) begin
        r_sec4 <= r_sec3;
        r_sec5 <= r_sec4;
    end

    always_comb begin
        case (r_sec5)
            SEC_RY: begin
                n_red = w_vo; n_green = w_t;  n_blue = w_p;
            end
            SEC_YG: begin
                n_red = w_q;  n_green = w_vo; n_blue = w_p;
            end
            SEC_GC: begin
                n_red = w_p;  n_green = w_vo; n_blue = w_t;
            end
            SEC_CB: begin
                n_red = w_p;  n_green = w_q;  n_blue = w_vo;
            end
            SEC_BM: begin
                n_red = w_t;  n_green = w_p;  n_blue = w_vo;
            end
            default: begin
                n_red = w_vo; n_green = w_p;  n_blue = w_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_done         = r_vld[STAGES-1];
    assign o_red_level    = r_red;
    assign o_green_level  = r_green;
    assign o_blue_level   = r_blue;
    assign o_packed_color = {r_green, r_red, r_blue};

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |-> ##6 o_done)
        else $error("accepted transaction did not complete after six cycles");

    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n, 6)) |-> $past(n_accept, 6))
        else $error("result strobe without an accepted transaction");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_accept && i_value_percent == '0) |-> ##6 (o_packed_color == '0))
        else $error("zero value did not give black");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_accept && i_saturation_percent == '0) |->
        ##6 (o_red_level == o_green_level && o_green_level == o_blue_level))
        else $error("zero saturation did not give gray");

endmodule
`default_nettype wire

// File: hdl/hsvg_cdiv.sv
`default_nettype none
module hsvg_cdiv #(
    parameter int XW    = 28,
    parameter int DIV   = 600000,
    parameter int SHIFT = 32
) (
    input  wire logic                        i_clk,
    input  wire logic [XW-1:0]               i_x,
    output logic      [hsvg_pkg::LEVEL_W-1:0] o_q
);
    import hsvg_pkg::*;

    localparam logic [63:0] RECIP = (64'd1 << SHIFT) / DIV;
    localparam int          MW    = $clog2(RECIP + 64'd1);
    localparam int          PW    = XW + MW;

    logic [PW-1:0]      n_prod;
    logic [LEVEL_W-1:0] r_est;
    logic [XW-1:0]      r_x;
    logic [XW-1:0]      n_back;
    logic [XW-1:0]      n_rem;
    logic [LEVEL_W-1:0] n_q;
    logic [LEVEL_W-1:0] r_q;

    // reciprocal estimate is exact or one short
    assign n_prod = PW'(i_x) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        r_est <= n_prod[SHIFT +: LEVEL_W];
        r_x   <= i_x;
    end

    always_comb begin
        n_back = XW'(r_est) * XW'(DIV);
        n_rem  = r_x - n_back;
        n_q    = (n_rem >= XW'(DIV)) ? r_est + LEVEL_W'(1) : r_est;
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule
`default_nettype wire
